@@ hw/rtl/hsl_to_rgb_converter_assert.svh @@
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shorthands for clocked concurrent checks with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// check prop at every rising clk edge while rst_n is high
`define HSLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every rising clk edge, reset cycles included
`define HSLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hslc_pkg.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Hue sector codes shared by the conversion pipeline.
// ----------------------------------------------------------------------------
package hslc_pkg;

    typedef logic [2:0] t_sector;

    localparam t_sector SECT_RED_RISE_GREEN  = 3'd0;
    localparam t_sector SECT_GREEN_FALL_RED  = 3'd1;
    localparam t_sector SECT_GREEN_RISE_BLUE = 3'd2;
    localparam t_sector SECT_BLUE_FALL_GREEN = 3'd3;
    localparam t_sector SECT_BLUE_RISE_RED   = 3'd4;
    localparam t_sector SECT_RED_FALL_BLUE   = 3'd5;

endpackage

@@ hw/rtl/hsl_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Five-stage pipeline turning hue/saturation/lightness into red/green/blue.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | i_valid / o_stall  | i_hue, i_saturation, i_lightness
//   output  | o_valid / i_stall  | o_red, o_green, o_blue
//
// One transaction per clock while the output is not stalled. The register
// stages are L*S product, channel max, min/spread, spread*fraction and
// channel select. Reset clears the valid bits of all stages. A stalled
// output holds its result while earlier stages keep filling any empty slot.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
    import hslc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_hue,
    input  logic [CHANNEL_BITS-1:0] i_saturation,
    input  logic [CHANNEL_BITS-1:0] i_lightness,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CHANNEL_BITS-1:0] o_red,
    output logic [CHANNEL_BITS-1:0] o_green,
    output logic [CHANNEL_BITS-1:0] o_blue
);

    localparam int W = CHANNEL_BITS;
    localparam logic [W+2:0] SIX  = (W+3)'(6);
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    logic [2*W-1:0] r_s1_ls;
    logic [W+2:0]   r_s1_h6;
    logic [W-1:0]   r_s1_l, r_s1_s;

    logic [W-1:0]   r_s2_q, r_s2_l;
    logic [W+2:0]   r_s2_h6;
    logic           r_s2_zero;

    logic [W-1:0]   r_s3_q, r_s3_p, r_s3_d, r_s3_f;
    t_sector        r_s3_sect;
    logic           r_s3_zero;

    logic [W-1:0]   r_s4_q, r_s4_p, r_s4_m;
    t_sector        r_s4_sect;
    logic           r_s4_zero;

    logic [W-1:0]   r_red, r_green, r_blue;

    logic [2*W-1:0] n_s1_ls;
    logic [W+2:0]   n_s1_h6;
    logic [W-1:0]   w_ls_hi;
    logic [W:0]     w_q_wide;
    logic [W-1:0]   n_s2_q;
    logic [W:0]     w_l2, w_qx;
    logic [W:0]     w_p_wide;
    logic [W-1:0]   w_q_minus_l;
    logic [W-1:0]   n_s3_p, n_s3_d;
    logic [2*W-1:0] w_md;
    logic [W-1:0]   w_rise, w_fall;
    logic [W-1:0]   n_red, n_green, n_blue;

    assign w_rdy5  = !r_vld5 || !i_stall;
    assign w_rdy4  = !r_vld4 || w_rdy5;
    assign w_rdy3  = !r_vld3 || w_rdy4;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
            if (w_rdy3) r_vld3 <= r_vld2;
            if (w_rdy4) r_vld4 <= r_vld3;
            if (w_rdy5) r_vld5 <= r_vld4;
        end
    end

    // stage 1: L*S and hue*6
    always_comb begin
        n_s1_ls = {{W{1'b0}}, i_lightness} * {{W{1'b0}}, i_saturation};
        n_s1_h6 = {3'b000, i_hue} * SIX;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_ls <= n_s1_ls;
            r_s1_h6 <= n_s1_h6;
            r_s1_l  <= i_lightness;
            r_s1_s  <= i_saturation;
        end
    end

    // stage 2: channel maximum q, saturated
    always_comb begin
        w_ls_hi = r_s1_ls[2*W-1:W];
        if (r_s1_l <= HALF) begin
            w_q_wide = {1'b0, r_s1_l} + {1'b0, w_ls_hi};
        end else begin
            w_q_wide = {1'b0, r_s1_l} + {1'b0, r_s1_s} - {1'b0, w_ls_hi};
        end
        n_s2_q = w_q_wide[W] ? {W{1'b1}} : w_q_wide[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_q    <= n_s2_q;
            r_s2_l    <= r_s1_l;
            r_s2_h6   <= r_s1_h6;
            r_s2_zero <= (n_s2_q == '0);
        end
    end

    // stage 3: minimum p and spread q-p
    always_comb begin
        w_l2        = {r_s2_l, 1'b0};
        w_qx        = {1'b0, r_s2_q};
        w_p_wide    = w_l2 - w_qx;
        w_q_minus_l = r_s2_q - r_s2_l;
        if (w_l2 > w_qx) begin
            n_s3_p = w_p_wide[W-1:0];
            n_s3_d = (r_s2_q > r_s2_l) ? {w_q_minus_l[W-2:0], 1'b0} : '0;
        end else begin
            n_s3_p = '0;
            n_s3_d = r_s2_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_q    <= r_s2_q;
            r_s3_p    <= n_s3_p;
            r_s3_d    <= n_s3_d;
            r_s3_f    <= r_s2_h6[W-1:0];
            r_s3_sect <= r_s2_h6[W+2:W];
            r_s3_zero <= r_s2_zero;
        end
    end

    // stage 4: spread times hue fraction
    assign w_md = {{W{1'b0}}, r_s3_d} * {{W{1'b0}}, r_s3_f};

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_q    <= r_s3_q;
            r_s4_p    <= r_s3_p;
            r_s4_m    <= w_md[2*W-1:W];
            r_s4_sect <= r_s3_sect;
            r_s4_zero <= r_s3_zero;
        end
    end

    // stage 5: rising/falling edges and channel assignment
    always_comb begin
        w_rise = r_s4_p + r_s4_m;
        w_fall = r_s4_q - r_s4_m;
        case (r_s4_sect)
            SECT_RED_RISE_GREEN: begin
                n_red = r_s4_q;  n_green = w_rise; n_blue = r_s4_p;
            end
            SECT_GREEN_FALL_RED: begin
                n_red = w_fall;  n_green = r_s4_q; n_blue = r_s4_p;
            end
            SECT_GREEN_RISE_BLUE: begin
                n_red = r_s4_p;  n_green = r_s4_q; n_blue = w_rise;
            end
            SECT_BLUE_FALL_GREEN: begin
                n_red = r_s4_p;  n_green = w_fall; n_blue = r_s4_q;
            end
            SECT_BLUE_RISE_RED: begin
                n_red = w_rise;  n_green = r_s4_p; n_blue = r_s4_q;
            end
            default: begin
                n_red = r_s4_q;  n_green = r_s4_p; n_blue = w_fall;
            end
        endcase
        if (r_s4_zero) begin
            n_red   = '0;
            n_green = '0;
            n_blue  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_vld5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ hw/rtl/hslc_checker.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB converter port checker
// Watches the converter's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hslc_checker #(
    parameter int CHANNEL_BITS = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [CHANNEL_BITS-1:0] o_red,
    input logic [CHANNEL_BITS-1:0] o_green,
    input logic [CHANNEL_BITS-1:0] o_blue
);

    logic                      w_out_wait;
    logic [3*CHANNEL_BITS-1:0] w_rgb;

    assign w_out_wait = o_valid && i_stall;
    assign w_rgb      = {o_red, o_green, o_blue};

    `HSLC_ASSERT(a_out_hold_valid, i_clk, i_rst_n, w_out_wait |=> o_valid, "stalled output dropped")
    `HSLC_ASSERT(a_out_hold_rgb, i_clk, i_rst_n, w_out_wait |=> $stable(w_rgb), "output moved")
    `HSLC_ASSERT(a_stall_follows, i_clk, i_rst_n, !i_stall |-> !o_stall, "stall without cause")
    `HSLC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

bind hsl_to_rgb_converter hslc_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hslc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);
